[sv/vertex_dedup_index_table_defines.svh]
// ---------------------------------------------------------------------------
// Vertex dedup index table: assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEX_TABLE_DEFINES_SVH
`define VERTEX_DEDUP_INDEX_TABLE_DEFINES_SVH

// Same-cycle implication.
`define VDIT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VDIT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vdit_pkg.sv]
// ---------------------------------------------------------------------------
// Vertex dedup index table: package
// Item types, controller command/status and IEEE equality helpers.
// ---------------------------------------------------------------------------
package vdit_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic        take_normal;
  } vertex_t;

  typedef struct packed {
    logic [7:0] pos_index;
    logic       pos_added;
    logic [7:0] uv_index;
    logic       uv_added;
    logic [7:0] normal_index;
    logic       normal_added;
    logic       normal_valid;
    logic       table_full;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the vertex, rewind the scan
    logic scan;     // read one row of every table, advance the address
    logic commit;   // insert misses, register the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // the address being read is the last row
  } status_t;

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // IEEE equality: signed zeros match, NaN never matches
  function automatic logic fp_eq(input logic [31:0] a, input logic [31:0] b);
    logic both_zero;
    both_zero = ((a | b) & 32'h7FFF_FFFF) == 32'd0;
    if (fp_is_nan(a) || fp_is_nan(b)) return 1'b0;
    return both_zero || (a == b);
  endfunction

endpackage

[sv/vdit_ctrl.sv]
// ---------------------------------------------------------------------------
// Vertex dedup index table: controller
// Sequences capture, table scan, drain, commit and the result strobe.
// ---------------------------------------------------------------------------
`include "vertex_dedup_index_table_defines.svh"

module vdit_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  vdit_pkg::status_t status,
  output vdit_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    cmd.capture = (state == S_IDLE) && start;
    cmd.scan    = (state == S_SCAN);
    cmd.commit  = (state == S_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            busy  <= 1'b1;
          end
        end
        S_SCAN: begin
          if (status.scan_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VDIT_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
  `VDIT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `VDIT_ASSERT_NXT(a_commit_done, cmd.commit, done, "commit not followed by strobe")

endmodule

[sv/vdit_datapath.sv]
// ---------------------------------------------------------------------------
// Vertex dedup index table: datapath
// Three entry tables, fill counts, shared scan address and match logic.
// ---------------------------------------------------------------------------
`include "vertex_dedup_index_table_defines.svh"

module vdit_datapath #(
  parameter int TABLE_DEPTH = vdit_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  vdit_pkg::cmd_t    cmd,
  input  vdit_pkg::vertex_t vertex,
  output vdit_pkg::status_t status,
  output vdit_pkg::result_t result
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  vdit_pkg::vertex_t vtx;

  logic [95:0] pos_mem [TABLE_DEPTH];
  logic [63:0] tex_mem [TABLE_DEPTH];
  logic [95:0] nrm_mem [TABLE_DEPTH];

  logic [95:0] pos_rd;
  logic [63:0] tex_rd;
  logic [95:0] nrm_rd;

  logic [CW-1:0] pos_count, tex_count, nrm_count;
  logic [AW-1:0] scan_addr, rd_addr;
  logic          rd_vld;

  logic          pos_found, tex_found, nrm_found;
  logic [AW-1:0] pos_idx, tex_idx, nrm_idx;

  logic pos_match, tex_match, nrm_match;
  logic pos_room, tex_room, nrm_room;
  logic pos_ins, tex_ins, nrm_ins;

  assign status.scan_last = (scan_addr == AW'(TABLE_DEPTH - 1));

  // Row compare on the registered read data; only filled rows count
  always_comb begin
    pos_match = rd_vld && (CW'(rd_addr) < pos_count) &&
                vdit_pkg::fp_eq(pos_rd[31:0], vtx.pos_x) &&
                vdit_pkg::fp_eq(pos_rd[63:32], vtx.pos_y) &&
                vdit_pkg::fp_eq(pos_rd[95:64], vtx.pos_z);
    tex_match = rd_vld && (CW'(rd_addr) < tex_count) &&
                vdit_pkg::fp_eq(tex_rd[31:0], vtx.tex_u) &&
                vdit_pkg::fp_eq(tex_rd[63:32], vtx.tex_v);
    nrm_match = rd_vld && (CW'(rd_addr) < nrm_count) &&
                vdit_pkg::fp_eq(nrm_rd[31:0], vtx.norm_x) &&
                vdit_pkg::fp_eq(nrm_rd[63:32], vtx.norm_y) &&
                vdit_pkg::fp_eq(nrm_rd[95:64], vtx.norm_z);
  end

  assign pos_room = pos_count < CW'(TABLE_DEPTH);
  assign tex_room = tex_count < CW'(TABLE_DEPTH);
  assign nrm_room = nrm_count < CW'(TABLE_DEPTH);
  assign pos_ins  = cmd.commit && !pos_found && pos_room;
  assign tex_ins  = cmd.commit && !tex_found && tex_room;
  assign nrm_ins  = cmd.commit && vtx.take_normal && !nrm_found && nrm_room;

  always_ff @(posedge clk) begin
    if (cmd.scan) pos_rd <= pos_mem[scan_addr];
    if (pos_ins) pos_mem[pos_count[AW-1:0]] <= {vtx.pos_z, vtx.pos_y, vtx.pos_x};
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) tex_rd <= tex_mem[scan_addr];
    if (tex_ins) tex_mem[tex_count[AW-1:0]] <= {vtx.tex_v, vtx.tex_u};
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) nrm_rd <= nrm_mem[scan_addr];
    if (nrm_ins) nrm_mem[nrm_count[AW-1:0]] <= {vtx.norm_z, vtx.norm_y, vtx.norm_x};
  end

  // Payload: latched vertex, first-hit indices, result
  always_ff @(posedge clk) begin
    if (cmd.capture) vtx <= vertex;
    rd_addr <= scan_addr;
    if (pos_match && !pos_found) pos_idx <= rd_addr;
    if (tex_match && !tex_found) tex_idx <= rd_addr;
    if (nrm_match && !nrm_found) nrm_idx <= rd_addr;
    if (cmd.commit) begin
      result.pos_index    <= pos_found ? 8'(pos_idx) : (pos_room ? 8'(pos_count) : 8'd0);
      result.pos_added    <= pos_ins;
      result.uv_index     <= tex_found ? 8'(tex_idx) : (tex_room ? 8'(tex_count) : 8'd0);
      result.uv_added     <= tex_ins;
      result.normal_index <= !vtx.take_normal ? 8'd0 :
                             nrm_found ? 8'(nrm_idx) : (nrm_room ? 8'(nrm_count) : 8'd0);
      result.normal_added <= nrm_ins;
      result.normal_valid <= vtx.take_normal && (nrm_found || nrm_room);
      result.table_full   <= (!pos_found && !pos_room) || (!tex_found && !tex_room) ||
                             (vtx.take_normal && !nrm_found && !nrm_room);
    end
  end

  // Control: scan address, read valid, hit flags, fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
      pos_found <= 1'b0;
      tex_found <= 1'b0;
      nrm_found <= 1'b0;
      pos_count <= '0;
      tex_count <= '0;
      nrm_count <= '0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.capture) begin
        scan_addr <= '0;
        pos_found <= 1'b0;
        tex_found <= 1'b0;
        nrm_found <= 1'b0;
      end else begin
        if (cmd.scan) scan_addr <= scan_addr + AW'(1);
        if (pos_match) pos_found <= 1'b1;
        if (tex_match) tex_found <= 1'b1;
        if (nrm_match) nrm_found <= 1'b1;
      end
      if (pos_ins) pos_count <= pos_count + CW'(1);
      if (tex_ins) tex_count <= tex_count + CW'(1);
      if (nrm_ins) nrm_count <= nrm_count + CW'(1);
    end
  end

  `VDIT_ASSERT_IMP(a_count_bound, 1'b1, pos_count <= CW'(TABLE_DEPTH), "position count overflow")
  `VDIT_ASSERT_NXT(a_pos_nonempty, cmd.commit, pos_count != '0, "position table empty after commit")
  `VDIT_ASSERT_NXT(a_nrm_untouched, cmd.commit && !vtx.take_normal, $stable(nrm_count) && !result.normal_valid, "normal table touched when not taken")

endmodule

[sv/vertex_dedup_index_table.sv]
// ---------------------------------------------------------------------------
// Vertex dedup index table: top level
// Deduplicates vertex positions, texture coordinates and normals into
// three tables of unique entries and returns an index for each.
// ---------------------------------------------------------------------------
//
//   channel   handshake             payload          direction
//   -------   -------------------   --------------   ---------
//   item in   start, busy           vertex (packed)  in
//   item out  done (one-cycle)      result (packed)  out
//
// Sequence: after accept, every row of the three tables is read through one
//   shared scan address, one row per cycle, followed by a drain state for
//   the registered read and a commit state before the result strobe.
// The next item may be accepted in the cycle that its predecessor's result
//   is strobed.
// Reset: synchronous rst empties all three tables by clearing their fill
//   counts; the table rows themselves are not cleared.
// Stalls: none on the output side; done lasts exactly one cycle and the
//   receiver must take the item then.
// ---------------------------------------------------------------------------
module vertex_dedup_index_table #(
  parameter int TABLE_DEPTH = vdit_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vdit_pkg::vertex_t vertex,
  output logic              done,
  output vdit_pkg::result_t result
);

  // Command and status between the controller and the datapath
  vdit_pkg::cmd_t    cmd;
  vdit_pkg::status_t status;

  // Sequence one item at a time: capture, scan, drain, commit, strobe
  vdit_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Hold the tables and counts; search, insert and register the result
  vdit_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .vertex (vertex),
    .status (status),
    .result (result)
  );

endmodule

[tb/sv/vertex_dedup_index_table_tb.sv]
// ---------------------------------------------------------------------------
// Vertex dedup index table: testbench
// Feeds vertices through the start/busy command port and checks every done
// strobe against a local model of the three dedup tables (positions,
// texture coordinates, normals). A short directed list covers signed zeros,
// NaN, infinities and skipped normals. Random vertices follow, biased toward
// repeats, and fill every table past its depth so that table-full results
// are reached.
// ---------------------------------------------------------------------------
module vertex_dedup_index_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH        = vdit_pkg::TABLE_DEPTH_DEF;
  localparam int          RANDOM_ITEMS = 1635;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int          REPORT_MAX   = 10;

  // Per-attribute miss rates (percent) for random vertices. Pick them so that
  // every table overflows at a different point of the run.
  localparam int unsigned POS_MISS_PCT  = 30;
  localparam int unsigned UV_MISS_PCT   = 20;
  localparam int unsigned NORM_MISS_PCT = 27;

  typedef enum int {
    ATTR_POS  = 0,
    ATTR_UV   = 1,
    ATTR_NORM = 2
  } attr_e;

  // One table row: up to three IEEE single patterns, component 0 first.
  typedef logic [2:0][31:0] row_t;

  typedef struct {
    vdit_pkg::vertex_t v;
    bit                typed;  // want holds an expectation written out by hand
    vdit_pkg::result_t want;
  } probe_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  vdit_pkg::vertex_t vertex;
  logic              done;
  vdit_pkg::result_t result;

  // Local copy of the tables and their fill counts.
  row_t        attr_rows [3][DEPTH];
  int unsigned attr_fill [3];

  vdit_pkg::result_t pending_results [$];
  probe_t            probes [$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned full_seen;
  int unsigned normals_skipped;
  int unsigned items_sent;
  bit          burst;

  vertex_dedup_index_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .vertex(vertex),
    .done  (done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // IEEE equality on bit patterns: any NaN fails, zeros of either sign agree.
  function automatic bit float_match(input logic [31:0] a, input logic [31:0] b);
    bit a_nan;
    bit b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (a_nan || b_nan) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b1;
    return a == b;
  endfunction

  // Search the filled rows of one table; append on a miss. Return 0 when the
  // table is full and the value is not there.
  function automatic bit find_or_append(input attr_e kind, input row_t val,
                                        output logic [7:0] idx, output logic added);
    int unsigned n;
    int          width;
    int          i;
    int          k;
    bit          same;
    n     = attr_fill[kind];
    width = (kind == ATTR_UV) ? 2 : 3;
    idx   = 8'd0;
    added = 1'b0;
    for (i = 0; i < n; i++) begin
      same = 1'b1;
      for (k = 0; k < width; k++)
        if (!float_match(attr_rows[kind][i][k], val[k])) same = 1'b0;
      if (same) begin
        idx = 8'(i);
        return 1'b1;
      end
    end
    if (n >= DEPTH) return 1'b0;
    attr_rows[kind][n] = val;
    attr_fill[kind]    = n + 1;
    idx                = 8'(n);
    added              = 1'b1;
    return 1'b1;
  endfunction

  function automatic vdit_pkg::result_t predict_indices(input vdit_pkg::vertex_t v);
    vdit_pkg::result_t r;
    row_t              p;
    row_t              t;
    row_t              nrm;
    r   = '0;
    p   = {v.pos_z, v.pos_y, v.pos_x};
    t   = {32'd0, v.tex_v, v.tex_u};
    nrm = {v.norm_z, v.norm_y, v.norm_x};
    if (!find_or_append(ATTR_POS, p, r.pos_index, r.pos_added)) r.table_full = 1'b1;
    if (!find_or_append(ATTR_UV, t, r.uv_index, r.uv_added)) r.table_full = 1'b1;
    if (v.take_normal) begin
      if (find_or_append(ATTR_NORM, nrm, r.normal_index, r.normal_added))
        r.normal_valid = 1'b1;
      else
        r.table_full = 1'b1;
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  function automatic vdit_pkg::vertex_t build_vertex(input row_t p, input row_t t,
                                                     input row_t nrm, input logic take);
    vdit_pkg::vertex_t v;
    v.pos_x       = p[0];
    v.pos_y       = p[1];
    v.pos_z       = p[2];
    v.tex_u       = t[0];
    v.tex_v       = t[1];
    v.norm_x      = nrm[0];
    v.norm_y      = nrm[1];
    v.norm_z      = nrm[2];
    v.take_normal = take;
    return v;
  endfunction

  // Corner patterns: signed zeros, infinities, NaNs, extremes, one.
  function automatic logic [31:0] float_corner(input int unsigned sel);
    case (sel)
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7F80_0000;
      3:       return 32'hFF80_0000;
      4:       return 32'h7FC0_0000;
      5:       return 32'h7F80_0001;
      6:       return 32'hFFFF_FFFF;
      7:       return 32'h7F7F_FFFF;
      8:       return 32'h0000_0001;
      default: return 32'h3F80_0000;
    endcase
  endfunction

  // Mostly reuse a stored row (with zero signs flipped at random) so the
  // search hits; otherwise build a fresh row that may share components with
  // stored ones, so partial matches occur.
  function automatic row_t draw_row(input attr_e kind, input int unsigned miss_pct);
    row_t        row;
    int unsigned fill;
    int unsigned pick;
    int          k;
    fill = attr_fill[kind];
    if (fill != 0 && $urandom_range(99) >= miss_pct) begin
      row = attr_rows[kind][$urandom_range(fill - 1)];
      for (k = 0; k < 3; k++)
        if (row[k][30:0] == 31'd0 && $urandom_range(1) == 1) row[k][31] = ~row[k][31];
    end else begin
      for (k = 0; k < 3; k++) begin
        pick = $urandom_range(15);
        if (pick < 4 && fill != 0)
          row[k] = attr_rows[kind][$urandom_range(fill - 1)][k];
        else if (pick < 6)
          row[k] = float_corner($urandom_range(9));
        else
          row[k] = $urandom();
      end
    end
    return row;
  endfunction

  function automatic vdit_pkg::vertex_t junk_vertex();
    row_t a;
    row_t b;
    row_t c;
    a = {$urandom(), $urandom(), $urandom()};
    b = {$urandom(), $urandom(), $urandom()};
    c = {$urandom(), $urandom(), $urandom()};
    return build_vertex(a, b, c, 1'($urandom_range(1)));
  endfunction

  function automatic void add_probe(input row_t p, input row_t t, input row_t nrm,
                                    input logic take, input bit typed,
                                    input vdit_pkg::result_t want);
    probe_t pr;
    pr.v     = build_vertex(p, t, nrm, take);
    pr.typed = typed;
    pr.want  = want;
    probes.insert(probes.size(), pr);
  endfunction

  // -------------------------------------------------------------------------
  // Driver: one item per call. Either hold start low for a random pause right
  // away (so the gap lands while the block is scanning), or first wait for
  // busy to drop and then idle (so the block sits empty). In a burst, raise
  // start at once and keep it high through busy.
  // -------------------------------------------------------------------------
  task automatic issue_vertex(input vdit_pkg::vertex_t v, input bit typed,
                              input vdit_pkg::result_t want);
    int unsigned       pause;
    bit                after_idle;
    vdit_pkg::result_t predicted;
    pause      = burst ? 0 : $urandom_range(0, 7);
    after_idle = !burst && ($urandom_range(1) == 1);
    if (pause > 0 || after_idle) begin
      start  <= 1'b0;
      vertex <= junk_vertex();
      if (after_idle) begin
        do @(posedge clk); while (busy);
        @(negedge clk);
      end
      repeat (pause) @(negedge clk);
    end
    vertex <= v;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    // Accepted at this edge: advance the local tables.
    predicted = predict_indices(v);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input vdit_pkg::result_t want,
                               input vdit_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("[%0t] MISMATCH %s:", $time, what);
      $display("  expected pos %0d/%0b uv %0d/%0b nrm %0d/%0b/%0b full %0b",
               want.pos_index, want.pos_added, want.uv_index, want.uv_added,
               want.normal_index, want.normal_added, want.normal_valid, want.table_full);
      $display("  got      pos %0d/%0b uv %0d/%0b nrm %0d/%0b/%0b full %0b",
               got.pos_index, got.pos_added, got.uv_index, got.uv_added,
               got.normal_index, got.normal_added, got.normal_valid, got.table_full);
    end
  endtask

  // Sample at the rising edge; the block updates its outputs after this
  // process reads them.
  always @(posedge clk) begin
    vdit_pkg::result_t want;
    string             bad;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, pending_results.size());
      $display("vertex_dedup_index_table test failed");
      $finish;
    end else if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, result);
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (result.pos_index !== want.pos_index)       bad = {bad, " pos_index"};
        if (result.pos_added !== want.pos_added)       bad = {bad, " pos_added"};
        if (result.uv_index !== want.uv_index)         bad = {bad, " uv_index"};
        if (result.uv_added !== want.uv_added)         bad = {bad, " uv_added"};
        if (result.normal_index !== want.normal_index) bad = {bad, " normal_index"};
        if (result.normal_added !== want.normal_added) bad = {bad, " normal_added"};
        if (result.normal_valid !== want.normal_valid) bad = {bad, " normal_valid"};
        if (result.table_full !== want.table_full)     bad = {bad, " table_full"};
        if (bad != "") note_mismatch({"fields", bad}, want, result);
        if (want.table_full) full_seen++;
        if (!want.normal_valid && !want.table_full) normals_skipped++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    row_t              p;
    row_t              t;
    row_t              nrm;
    vdit_pkg::result_t none;
    int                i;

    rst             = 1'b1;
    start           = 1'b0;
    vertex          = '0;
    cycle_count     = 0;
    mismatch_count  = 0;
    results_seen    = 0;
    full_seen       = 0;
    normals_skipped = 0;
    items_sent      = 0;
    burst           = 1'b0;
    none            = '0;
    for (i = 0; i < 3; i++) attr_fill[i] = 0;

    // Directed vertices. Tables start empty, so the first four results can
    // be written out: first inserts, negative zeros hitting positive zeros
    // with the normal skipped, then NaN rows that never match themselves.
    add_probe({32'h0, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h0},
              {32'h3F80_0000, 32'h0, 32'h0}, 1'b1,
              1'b1, '{8'd0, 1'b1, 8'd0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0});
    add_probe({32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
              {32'h0, 32'h0, 32'h8000_0000},
              {32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F}, 1'b0,
              1'b1, '{8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0});
    add_probe({3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}, 1'b1,
              1'b1, '{8'd1, 1'b1, 8'd1, 1'b1, 8'd1, 1'b1, 1'b1, 1'b0});
    add_probe({3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}, 1'b1,
              1'b1, '{8'd2, 1'b1, 8'd2, 1'b1, 8'd2, 1'b1, 1'b1, 1'b0});
    // Infinities, largest finite, smallest denormals; then the same again.
    add_probe({32'h7F7F_FFFF, 32'hFF80_0000, 32'h7F80_0000},
              {32'h0, 32'h8000_0001, 32'h1},
              {32'h8000_0000, 32'h0, 32'h7F80_0000}, 1'b1, 1'b0, none);
    add_probe({32'h7F7F_FFFF, 32'hFF80_0000, 32'h7F80_0000},
              {32'h0, 32'h8000_0001, 32'h1},
              {32'h8000_0000, 32'h0, 32'h7F80_0000}, 1'b1, 1'b0, none);
    // Partial matches: one component differs, or is a quiet NaN.
    add_probe({32'h7FC0_0000, 32'hFF80_0000, 32'h7F80_0000},
              {32'h0, 32'h8000_0000, 32'h1},
              {32'h0, 32'h0, 32'h7F80_0001}, 1'b1, 1'b0, none);
    // Normal offered but not taken; the next vertex takes the same normal.
    add_probe({32'h0, 32'h0, 32'h3F80_0000}, {32'h0, 32'h8000_0000, 32'h0},
              {32'hBF80_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, 1'b0, none);
    add_probe({32'h0, 32'h0, 32'h3F80_0000}, {32'h0, 32'h8000_0000, 32'h0},
              {32'hBF80_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1, 1'b0, none);
    add_probe({32'h0, 32'h0, 32'h8000_0000}, {32'h0, 32'h8000_0000, 32'h0},
              {32'hBF80_0000, 32'h0, 32'h0}, 1'b1, 1'b0, none);
    // Alternating bit patterns on every field.
    add_probe({3{32'hAAAA_AAAA}}, {3{32'hAAAA_AAAA}}, {3{32'hAAAA_AAAA}}, 1'b1,
              1'b0, none);
    add_probe({3{32'h5555_5555}}, {3{32'h5555_5555}}, {3{32'h5555_5555}}, 1'b1,
              1'b0, none);
    add_probe({32'h8000_0000, 32'h0, 32'h0}, {32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
              {32'h3F80_0000, 32'h8000_0000, 32'h0}, 1'b1, 1'b0, none);
    add_probe({32'h7F7F_FFFF, 32'hFF80_0000, 32'h7F80_0000},
              {32'h0, 32'h8000_0001, 32'h1},
              {32'h0, 32'h8000_0000, 32'h7F80_0000}, 1'b1, 1'b0, none);
    add_probe({32'h807F_FFFF, 32'h0080_0000, 32'hFF7F_FFFF},
              {32'h0, 32'hFF80_0000, 32'h7F80_0000},
              {32'h0, 32'h0, 32'h0}, 1'b0, 1'b0, none);

    // Hold reset, then release it between edges.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (probes[j]) issue_vertex(probes[j].v, probes[j].typed, probes[j].want);

    // Random vertices: mostly repeats, enough fresh rows to overflow every
    // table partway through. Switch between bursts and idling now and then.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(39) == 0) burst = !burst;
      p   = draw_row(ATTR_POS, POS_MISS_PCT);
      t   = draw_row(ATTR_UV, UV_MISS_PCT);
      nrm = draw_row(ATTR_NORM, NORM_MISS_PCT);
      issue_vertex(build_vertex(p, t, nrm, 1'($urandom_range(3) != 0)), 1'b0, none);
    end
    start  <= 1'b0;
    vertex <= junk_vertex();

    // Drain, then watch a full scan longer for stray strobes.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 40) @(posedge clk);

    $display("sent %0d vertices, checked %0d results: %0d hit a full table, %0d %s",
             items_sent, results_seen, full_seen, normals_skipped, "skipped the normal");
    $display("table fill at end: positions %0d, uv %0d, normals %0d of %0d; %0d mismatches",
             attr_fill[ATTR_POS], attr_fill[ATTR_UV], attr_fill[ATTR_NORM], DEPTH,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("vertex_dedup_index_table test passed");
    end else begin
      $display("vertex_dedup_index_table test failed");
    end
    $finish;
  end

endmodule
